[hw/rtl/barometric_sensor_compensation_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the barometric sensor compensation block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BSC_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) (pre) |-> (post)) \
        else $error("bsc check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BSC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("bsc check failed");

`endif

[hw/rtl/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// Barometric sensor compensation package
// Shared types, constants and arithmetic helpers.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int FRONT_DEPTH = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int DIV_BITS    = 64;
    localparam int DIV_FIRST   = 12;
    localparam int POST_DIV    = DIV_FIRST + DIV_BITS;
    localparam int BACK_DEPTH  = POST_DIV + 7;

    localparam logic [1:0] CFG_TEMP_TRIM    = 2'd0;
    localparam logic [1:0] CFG_PRESS_TRIM_A = 2'd1;
    localparam logic [1:0] CFG_PRESS_TRIM_B = 2'd2;
    localparam logic [1:0] CFG_PRESS_TRIM_C = 2'd3;

    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_BASE  = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [63:0] ONE_47      = 64'd1 << 47;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_trim;

    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] tc;
        logic [19:0] adc_p;
    } t_item;

    typedef struct packed {
        logic  push;
        t_item data;
    } t_qwr;

    typedef struct packed {
        logic  empty;
        t_item data;
    } t_qrd;

    // Partial products of a 64 x 64 multiply, low 64 bits only.
    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] c1;
        logic [31:0] c2;
    } t_pp;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic t_pp pp64(input logic [63:0] a, input logic [63:0] b);
        t_pp         r;
        logic [63:0] m1;
        logic [63:0] m2;
        r.lo = a[31:0] * b[31:0];
        m1   = a[63:32] * b[31:0];
        m2   = a[31:0] * b[63:32];
        r.c1 = m1[31:0];
        r.c2 = m2[31:0];
        return r;
    endfunction

    function automatic logic [63:0] pp_sum(input t_pp p);
        logic [31:0] c;
        c = p.c1 + p.c2;
        return p.lo + {c, 32'd0};
    endfunction

endpackage

[hw/rtl/bsc_queue.sv]
// ----------------------------------------------------------------------------
// Sample queue
// Short FIFO between the temperature front end and the pressure back end.
// ----------------------------------------------------------------------------
module bsc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bsc_pkg::t_qwr i_wr,
    output logic          o_full,
    input  logic          i_pop,
    output bsc_pkg::t_qrd o_rd
);
    import bsc_pkg::*;

    t_item               r_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push_ok;
    logic                pop_ok;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push_ok = i_wr.push && !o_full;
    assign pop_ok  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_comb begin
        o_rd.empty = (r_count == '0);
        o_rd.data  = r_mem[r_rptr];
    end

endmodule

[hw/rtl/bsc_front.sv]
// ----------------------------------------------------------------------------
// Temperature front end
// Accepts samples and runs the 32-bit fine temperature pipeline.
// ----------------------------------------------------------------------------
module bsc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bsc_pkg::t_trim i_trim,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [19:0]    i_raw_temperature,
    input  logic [19:0]    i_raw_pressure,
    input  logic           i_full,
    output bsc_pkg::t_qwr  o_wr
);
    import bsc_pkg::*;

    logic        r_fvld [0:FRONT_DEPTH-1];
    logic [19:0] r_fp   [0:FRONT_DEPTH-1];
    logic [19:0] r_adc_t;
    logic [31:0] r_u;
    logic [31:0] r_d;
    logic [31:0] r_m1;
    logic [31:0] r_dd;
    logic [31:0] r_a;
    logic [31:0] r_m2;
    logic [31:0] r_fine4;
    logic [31:0] r_fine5;
    logic [31:0] r_tc;
    logic        fen;
    logic [31:0] t1w;
    logic [31:0] t2w;
    logic [31:0] t3w;
    logic [31:0] e_w;
    logic [31:0] n_tcraw;

    assign fen     = !r_fvld[FRONT_DEPTH-1] || !i_full;
    assign o_ready = fen;
    assign t1w     = {16'd0, i_trim.t1};
    assign t2w     = {{16{i_trim.t2[15]}}, i_trim.t2};
    assign t3w     = {{16{i_trim.t3[15]}}, i_trim.t3};
    assign e_w     = $signed(r_dd) >>> 12;
    assign n_tcraw = r_fine4 * 32'd5 + 32'd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRONT_DEPTH; k++) begin
                r_fvld[k] <= 1'b0;
            end
        end else if (fen) begin
            r_fvld[0] <= i_valid;
            for (int k = 1; k < FRONT_DEPTH; k++) begin
                r_fvld[k] <= r_fvld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fen) begin
            r_adc_t <= i_raw_temperature;
            r_fp[0] <= i_raw_pressure;
            for (int k = 1; k < FRONT_DEPTH; k++) begin
                r_fp[k] <= r_fp[k-1];
            end
            r_u     <= {15'd0, r_adc_t[19:3]} - {t1w[30:0], 1'b0};
            r_d     <= {16'd0, r_adc_t[19:4]} - t1w;
            r_m1    <= r_u * t2w;
            r_dd    <= r_d * r_d;
            r_a     <= $signed(r_m1) >>> 11;
            r_m2    <= e_w * t3w;
            r_fine4 <= r_a + 32'($signed(r_m2) >>> 14);
            r_fine5 <= r_fine4;
            r_tc    <= $signed(n_tcraw) >>> 8;
        end
    end

    always_comb begin
        o_wr.push       = r_fvld[FRONT_DEPTH-1];
        o_wr.data.fine  = r_fine5;
        o_wr.data.tc    = r_tc;
        o_wr.data.adc_p = r_fp[FRONT_DEPTH-1];
    end

endmodule

[hw/rtl/bsc_back.sv]
// ----------------------------------------------------------------------------
// Pressure back end
// Runs the 64-bit pressure pipeline with a bit-per-stage divider.
// ----------------------------------------------------------------------------
module bsc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bsc_pkg::t_trim i_trim,
    input  bsc_pkg::t_qrd  i_rd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_temperature_centideg,
    output logic [31:0]    o_pressure_q24_8,
    output logic           o_divide_fault
);
    import bsc_pkg::*;

    logic        r_bvld [0:BACK_DEPTH-1];
    logic [31:0] r_btc  [0:BACK_DEPTH-1];
    logic        r_bflt [DIV_FIRST-1:BACK_DEPTH-1];
    logic [19:0] r_bp   [0:8];

    logic [63:0] r_x0;
    t_pp         r_pp_xx, r_pp_x5, r_pp_x2;
    logic [63:0] r_xx, r_xp5, r_xp2;
    t_pp         r_pp_x6, r_pp_x3;
    logic [63:0] r_xp5_3, r_xp2_3;
    logic [63:0] r_xxp6, r_xxp3, r_xp5_4, r_xp2_4;
    logic [63:0] r_y5, r_v;
    t_pp         r_pp_v1;
    logic [63:0] r_y6, r_w, r_y7;
    logic [63:0] r_xd, r_pn;
    t_pp         r_pp_n;
    logic [63:0] r_xd9, r_num, r_xd10;

    logic [63:0] r_rem [0:DIV_BITS];
    logic [63:0] r_qd  [0:DIV_BITS];
    logic [63:0] r_dv  [0:DIV_BITS];
    logic        r_ng  [0:DIV_BITS];
    logic [63:0] n_sh  [0:DIV_BITS-1];
    logic        n_ge  [0:DIV_BITS-1];
    logic [63:0] n_rem [0:DIV_BITS-1];
    logic [63:0] n_qd  [0:DIV_BITS-1];

    logic [63:0] r_p;
    t_pp         r_pp_9h, r_pp_8p;
    logic [63:0] r_h13, r_p13;
    logic [63:0] r_p9h, r_p8p, r_h14, r_p14;
    t_pp         r_pp_hh;
    logic [63:0] r_c2, r_p15;
    logic [63:0] r_p9hh, r_c2_16, r_p16;
    logic [63:0] r_s;
    logic [31:0] r_press;

    logic        ben;
    logic [63:0] n_fine64;
    logic [63:0] n_pbase;
    logic [63:0] n_out64;
    logic [63:0] n_h;

    assign ben   = !r_bvld[BACK_DEPTH-1] || i_ready;
    assign o_pop = ben && !i_rd.empty;

    assign n_fine64 = {{32{i_rd.data.fine[31]}}, i_rd.data.fine};
    assign n_pbase  = PRESS_BASE - {44'd0, r_bp[7]};
    assign n_h      = $signed(r_p) >>> 13;
    assign n_out64  = ($signed(r_s) >>> 8)
                      + {{44{i_trim.p7[15]}}, i_trim.p7, 4'd0};

    always_comb begin
        for (int k = 0; k < DIV_BITS; k++) begin
            n_sh[k]  = {r_rem[k][62:0], r_qd[k][63]};
            n_ge[k]  = (n_sh[k] >= r_dv[k]);
            n_rem[k] = n_ge[k] ? (n_sh[k] - r_dv[k]) : n_sh[k];
            n_qd[k]  = {r_qd[k][62:0], n_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BACK_DEPTH; k++) begin
                r_bvld[k] <= 1'b0;
            end
        end else if (ben) begin
            r_bvld[0] <= o_pop;
            for (int k = 1; k < BACK_DEPTH; k++) begin
                r_bvld[k] <= r_bvld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ben) begin
            r_btc[0] <= i_rd.data.tc;
            for (int k = 1; k < BACK_DEPTH; k++) begin
                r_btc[k] <= r_btc[k-1];
            end
            r_bflt[DIV_FIRST-1] <= (r_xd10 == 64'd0);
            for (int k = DIV_FIRST; k < BACK_DEPTH; k++) begin
                r_bflt[k] <= r_bflt[k-1];
            end
            r_bp[0] <= i_rd.data.adc_p;
            for (int k = 1; k < 9; k++) begin
                r_bp[k] <= r_bp[k-1];
            end

            r_x0    <= n_fine64 - FINE_OFFSET;
            r_pp_xx <= pp64(r_x0, r_x0);
            r_pp_x5 <= pp64(r_x0, sx16(i_trim.p5));
            r_pp_x2 <= pp64(r_x0, sx16(i_trim.p2));
            r_xx    <= pp_sum(r_pp_xx);
            r_xp5   <= pp_sum(r_pp_x5);
            r_xp2   <= pp_sum(r_pp_x2);
            r_pp_x6 <= pp64(r_xx, sx16(i_trim.p6));
            r_pp_x3 <= pp64(r_xx, sx16(i_trim.p3));
            r_xp5_3 <= r_xp5;
            r_xp2_3 <= r_xp2;
            r_xxp6  <= pp_sum(r_pp_x6);
            r_xxp3  <= pp_sum(r_pp_x3);
            r_xp5_4 <= r_xp5_3;
            r_xp2_4 <= r_xp2_3;
            r_y5    <= r_xxp6 + {r_xp5_4[46:0], 17'd0}
                       + {{13{i_trim.p4[15]}}, i_trim.p4, 35'd0};
            r_v     <= ONE_47 + (64'($signed(r_xxp3) >>> 8) + {r_xp2_4[51:0], 12'd0});
            r_pp_v1 <= pp64(r_v, {48'd0, i_trim.p1});
            r_y6    <= r_y5;
            r_w     <= pp_sum(r_pp_v1);
            r_y7    <= r_y6;
            r_xd    <= $signed(r_w) >>> 33;
            r_pn    <= {n_pbase[32:0], 31'd0} - r_y7;
            r_pp_n  <= pp64(r_pn, PRESS_SCALE);
            r_xd9   <= r_xd;
            r_num   <= pp_sum(r_pp_n);
            r_xd10  <= r_xd9;

            r_rem[0] <= 64'd0;
            r_qd[0]  <= r_num[63] ? (64'd0 - r_num) : r_num;
            r_dv[0]  <= r_xd10[63] ? (64'd0 - r_xd10) : r_xd10;
            r_ng[0]  <= r_num[63] ^ r_xd10[63];
            for (int k = 0; k < DIV_BITS; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_qd[k+1]  <= n_qd[k];
                r_dv[k+1]  <= r_dv[k];
                r_ng[k+1]  <= r_ng[k];
            end

            r_p     <= r_ng[DIV_BITS] ? (64'd0 - r_qd[DIV_BITS]) : r_qd[DIV_BITS];
            r_pp_9h <= pp64(sx16(i_trim.p9), n_h);
            r_pp_8p <= pp64(sx16(i_trim.p8), r_p);
            r_h13   <= n_h;
            r_p13   <= r_p;
            r_p9h   <= pp_sum(r_pp_9h);
            r_p8p   <= pp_sum(r_pp_8p);
            r_h14   <= r_h13;
            r_p14   <= r_p13;
            r_pp_hh <= pp64(r_p9h, r_h14);
            r_c2    <= $signed(r_p8p) >>> 19;
            r_p15   <= r_p14;
            r_p9hh  <= pp_sum(r_pp_hh);
            r_c2_16 <= r_c2;
            r_p16   <= r_p15;
            r_s     <= r_p16 + 64'($signed(r_p9hh) >>> 25) + r_c2_16;
            r_press <= r_bflt[BACK_DEPTH-2] ? 32'd0 : n_out64[31:0];
        end
    end

    assign o_valid                = r_bvld[BACK_DEPTH-1];
    assign o_temperature_centideg = r_btc[BACK_DEPTH-1];
    assign o_pressure_q24_8       = r_press;
    assign o_divide_fault         = r_bflt[BACK_DEPTH-1];

endmodule

[hw/rtl/barometric_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// Barometric sensor compensation
// Integer temperature and 64-bit pressure compensation with trim registers.
//
//   Channel   Signals                          Direction
//   sample    i_valid / o_ready, raw fields    in
//   result    o_valid / i_ready, comp. fields  out
//   trim      i_cfg_we, i_cfg_idx, i_cfg_wdata in
//
// One sample is taken every cycle while neither side stalls.
// A sample passes through the temperature front end, the queue and the pressure
// back end, which holds the bit-per-stage divider. Reset is synchronous and
// clears all valid state and trim values. A stalled result holds the back
// end; the queue lets the front end continue.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [19:0]        i_raw_temperature,
    input  logic [19:0]        i_raw_pressure,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_temperature_centideg,
    output logic [31:0]        o_pressure_q24_8,
    output logic               o_divide_fault
);
    import bsc_pkg::*;

    logic [47:0] r_temp_trim;
    logic [47:0] r_press_a;
    logic [47:0] r_press_b;
    logic [47:0] r_press_c;
    t_trim       trim;
    t_qwr        qwr;
    t_qrd        qrd;
    logic        q_full;
    logic        q_pop;
    logic [31:0] temp_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim <= '0;
            r_press_a   <= '0;
            r_press_b   <= '0;
            r_press_c   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMP_TRIM:    r_temp_trim <= i_cfg_wdata;
                CFG_PRESS_TRIM_A: r_press_a   <= i_cfg_wdata;
                CFG_PRESS_TRIM_B: r_press_b   <= i_cfg_wdata;
                CFG_PRESS_TRIM_C: r_press_c   <= i_cfg_wdata;
                default:          r_temp_trim <= r_temp_trim;
            endcase
        end
    end

    always_comb begin
        trim.t1 = r_temp_trim[15:0];
        trim.t2 = r_temp_trim[31:16];
        trim.t3 = r_temp_trim[47:32];
        trim.p1 = r_press_a[15:0];
        trim.p2 = r_press_a[31:16];
        trim.p3 = r_press_a[47:32];
        trim.p4 = r_press_b[15:0];
        trim.p5 = r_press_b[31:16];
        trim.p6 = r_press_b[47:32];
        trim.p7 = r_press_c[15:0];
        trim.p8 = r_press_c[31:16];
        trim.p9 = r_press_c[47:32];
    end

    bsc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_trim            (trim),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .i_full            (q_full),
        .o_wr              (qwr)
    );

    bsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (qwr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rd    (qrd)
    );

    bsc_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_trim                 (trim),
        .i_rd                   (qrd),
        .o_pop                  (q_pop),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_temperature_centideg (temp_out),
        .o_pressure_q24_8       (o_pressure_q24_8),
        .o_divide_fault         (o_divide_fault)
    );

    assign o_temperature_centideg = $signed(temp_out);

endmodule

[hw/rtl/bsc_checker.sv]
// ----------------------------------------------------------------------------
// Port checker
// Watches the result channel of the compensation block over time.
// ----------------------------------------------------------------------------
`include "barometric_sensor_compensation_assert.svh"

module bsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_temperature_centideg,
    input logic [31:0] o_pressure_q24_8,
    input logic        o_divide_fault
);

    `BSC_ASSERT_NEXT(a_reset_clears, !i_rst_n, !o_valid)
    `BSC_ASSERT_IMPL(a_fault_zero, i_rst_n && o_valid && o_divide_fault, o_pressure_q24_8 == 32'd0)
    `BSC_ASSERT_NEXT(a_hold_result, i_rst_n && o_valid && !i_ready, o_valid && $stable(o_pressure_q24_8))
    `BSC_ASSERT_NEXT(a_hold_temp, i_rst_n && o_valid && !i_ready, $stable(o_temperature_centideg) && $stable(o_divide_fault))

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (.*);
